/* hw/rtl/lcdws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD write sequencer package
// Shared constants, command and status types, and the init command table.
// ----------------------------------------------------------------------------
package lcdws_pkg;

    // Request kinds.
    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_CMD  = 2'd1;
    localparam logic [1:0] REQ_CHAR = 2'd2;
    localparam logic [1:0] REQ_NUM  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_WAIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_EXTRA   = 8'd3;

    // Register reset values.
    localparam logic [7:0] RST_POWER_ON_WAIT = 8'd20;
    localparam logic [7:0] RST_ENABLE_PULSE  = 8'd2;
    localparam logic [7:0] RST_SETTLE        = 8'd2;
    localparam logic [7:0] RST_CLEAR_EXTRA   = 8'd5;

    // Init command sequence.
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_CLEAR        = 8'h01;
    localparam int         INIT_STEPS       = 4;
    localparam int         INIT_IDX_W       = $clog2(INIT_STEPS);

    // Decimal conversion.
    localparam int         NUM_W       = 32;
    localparam int         BIT_CNT_W   = $clog2(NUM_W);
    localparam int         BCD_DIGITS  = 10;
    localparam int         BCD_W       = 4 * BCD_DIGITS;
    localparam int         MAX_DIGITS  = 10;
    localparam int         DIGIT_COUNT = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
    localparam int         DIDX_W      = $clog2(BCD_DIGITS);
    localparam logic [7:0] ASCII_ZERO  = 8'd48;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_init;
        logic emit_byte;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_last;
        logic lead_zero;
        logic didx_zero;
        logic init_last;
    } t_dp_stat;

    function automatic logic [7:0] f_init_byte(input logic [INIT_IDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = LCD_FUNCTION_SET;
            2'd1:    b = LCD_DISPLAY_ON;
            2'd2:    b = LCD_ENTRY_MODE;
            default: b = LCD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/lcdws_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD write sequencer controller
// Request state machine that steps the datapath through each request.
// ----------------------------------------------------------------------------
module lcdws_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_req_type,
    input  lcdws_pkg::t_dp_stat i_stat,
    output lcdws_pkg::t_dp_cmd  o_cmd,
    output logic                busy
);
    import lcdws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_BYTE,
        ST_CONV,
        ST_SKIP,
        ST_DIGIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type)
                        REQ_INIT:          n_state = ST_INIT;
                        REQ_CMD, REQ_CHAR: n_state = ST_BYTE;
                        default:           n_state = ST_CONV;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.emit_init = 1'b1;
                if (i_stat.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BYTE: begin
                o_cmd.emit_byte = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_stat.conv_last) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_stat.lead_zero) begin
                    o_cmd.skip_step = 1'b1;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_stat.didx_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

/* hw/rtl/lcdws_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD write sequencer datapath
// Configuration registers, binary to BCD converter and strobe word register.
// ----------------------------------------------------------------------------
module lcdws_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lcdws_pkg::t_dp_cmd                   i_cmd,
    output lcdws_pkg::t_dp_stat                  o_stat,
    input  logic                                 i_cfg_valid,
    input  logic [lcdws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                           i_cfg_data,
    input  logic [1:0]                           i_req_type,
    input  logic [7:0]                           i_char_byte,
    input  logic [lcdws_pkg::NUM_W-1:0]          i_number_value,
    output logic                                 o_strobe,
    output logic                                 o_reg_select,
    output logic [7:0]                           o_bus_byte,
    output logic [7:0]                           o_wait_before_ms,
    output logic [7:0]                           o_enable_high_ms,
    output logic [8:0]                           o_wait_after_ms,
    output logic                                 o_last
);
    import lcdws_pkg::*;

    logic [7:0]            r_power_on_wait;
    logic [7:0]            r_enable_pulse;
    logic [7:0]            r_settle;
    logic [7:0]            r_clear_extra;

    logic                  r_rs_char;
    logic [7:0]            r_char;
    logic [NUM_W-1:0]      r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd_adj;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [DIDX_W-1:0]     r_didx;
    logic [INIT_IDX_W-1:0] r_init_idx;
    logic [3:0]            cur_digit;

    logic                  r_strobe;
    logic                  r_rs;
    logic [7:0]            r_byte;
    logic [7:0]            r_before;
    logic [7:0]            r_enable;
    logic [8:0]            r_after;
    logic                  r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_on_wait <= RST_POWER_ON_WAIT;
            r_enable_pulse  <= RST_ENABLE_PULSE;
            r_settle        <= RST_SETTLE;
            r_clear_extra   <= RST_CLEAR_EXTRA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POWER_ON_WAIT: r_power_on_wait <= i_cfg_data;
                CFG_ENABLE_PULSE:  r_enable_pulse  <= i_cfg_data;
                CFG_SETTLE:        r_settle        <= i_cfg_data;
                CFG_CLEAR_EXTRA:   r_clear_extra   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Add-3 correction on every BCD digit before the shift.
    always_comb begin
        n_bcd_adj = r_bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    assign cur_digit = r_bcd[{r_didx, 2'b00} +: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rs_char  <= (i_req_type == REQ_CHAR);
            r_char     <= i_char_byte;
            r_bin      <= i_number_value;
            r_bcd      <= '0;
            r_bit_cnt  <= '0;
            r_didx     <= DIDX_W'(DIGIT_COUNT - 1);
            r_init_idx <= '0;
        end else begin
            if (i_cmd.conv_step) begin
                r_bcd     <= {n_bcd_adj[BCD_W-2:0], r_bin[NUM_W-1]};
                r_bin     <= {r_bin[NUM_W-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end
            if (i_cmd.skip_step || i_cmd.emit_digit) begin
                r_didx <= r_didx - 1'b1;
            end
            if (i_cmd.emit_init) begin
                r_init_idx <= r_init_idx + 1'b1;
            end
        end
    end

    // A zero is only a leading zero when no digit above the emitted window is
    // set, so a value cut down to the low digits keeps its inner zeros.
    always_comb begin
        o_stat.conv_last = (r_bit_cnt == BIT_CNT_W'(NUM_W - 1));
        o_stat.didx_zero = (r_didx == '0);
        o_stat.lead_zero = (cur_digit == 4'd0) && (r_didx != '0)
                           && ((r_bcd >> (4 * DIGIT_COUNT)) == '0);
        o_stat.init_last = (r_init_idx == INIT_IDX_W'(INIT_STEPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_init | i_cmd.emit_byte | i_cmd.emit_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_enable <= r_enable_pulse;
        r_before <= 8'd0;
        r_after  <= {1'b0, r_settle};
        if (i_cmd.emit_init) begin
            r_rs   <= 1'b0;
            r_byte <= f_init_byte(r_init_idx);
            r_last <= o_stat.init_last;
            if (r_init_idx == '0) begin
                r_before <= r_power_on_wait;
            end
            if (o_stat.init_last) begin
                r_after <= {1'b0, r_settle} + {1'b0, r_clear_extra};
            end
        end else if (i_cmd.emit_byte) begin
            r_rs   <= r_rs_char;
            r_byte <= r_char;
            r_last <= 1'b1;
        end else begin
            r_rs   <= 1'b1;
            r_byte <= ASCII_ZERO + {4'd0, cur_digit};
            r_last <= o_stat.didx_zero;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_reg_select     = r_rs;
    assign o_bus_byte       = r_byte;
    assign o_wait_before_ms = r_before;
    assign o_enable_high_ms = r_enable;
    assign o_wait_after_ms  = r_after;
    assign o_last           = r_last;

endmodule

/* hw/rtl/char_lcd_write_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD write sequencer
// Turns init, command, character and decimal number requests into strobe
// words for a downstream pin stage driving an 8-bit character LCD.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low. Each
// strobe word appears for exactly one cycle with o_strobe high and must be
// captured then, as the block cannot be stalled; o_last marks the final word of
// a request. An init request gives four words; a command or character request
// gives one word. A number request first runs the bit-serial binary to BCD
// converter, which handles one bit of the value per cycle over all 32 bits,
// then steps through the ten digit positions from the top, each either a
// skipped leading zero or an emitted digit; the skip ends when the first
// nonzero digit or the last digit is reached. Busy falls as the last word is
// issued, so the next request may be accepted while that word is still being
// presented. The configuration write channel is always ready; writes should be
// made only while the block is idle, and writes to an unknown index are
// ignored.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_req_type,
    input  logic [7:0]                      i_char_byte,
    input  logic [lcdws_pkg::NUM_W-1:0]     i_number_value,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lcdws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    output logic                            o_strobe,
    output logic                            o_reg_select,
    output logic [7:0]                      o_bus_byte,
    output logic [7:0]                      o_wait_before_ms,
    output logic [7:0]                      o_enable_high_ms,
    output logic [8:0]                      o_wait_after_ms,
    output logic                            o_last
);
    import lcdws_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Registers may be written in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each request; the datapath holds the
    // configuration, the conversion registers and the output word.
    lcdws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .busy       (busy)
    );

    lcdws_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_char_byte      (i_char_byte),
        .i_number_value   (i_number_value),
        .o_strobe         (o_strobe),
        .o_reg_select     (o_reg_select),
        .o_bus_byte       (o_bus_byte),
        .o_wait_before_ms (o_wait_before_ms),
        .o_enable_high_ms (o_enable_high_ms),
        .o_wait_after_ms  (o_wait_after_ms),
        .o_last           (o_last)
    );

`ifndef SYNTH
    // The final word of a request is never followed directly by another.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("strobe word directly after a final word");

    // An accepted request makes the block busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted request");

    // Words are only issued while a request is in progress.
    a_strobe_in_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("strobe word without a request in progress");

    // Only the function set command of an init carries a power-on wait.
    a_power_on_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_wait_before_ms != 8'd0) |->
            (o_bus_byte == LCD_FUNCTION_SET) && !o_reg_select)
        else $error("power-on wait on a word other than function set");
`endif

endmodule
